FILE: rtl/core/key_matrix_hid_report_engine_core_macros.svh
// Assertion helpers for the report engine core
`ifndef KEY_MATRIX_HID_REPORT_ENGINE_CORE_MACROS_SVH
`define KEY_MATRIX_HID_REPORT_ENGINE_CORE_MACROS_SVH

`define KMH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define KMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/kmh_pkg.sv
`default_nettype none
package kmh_pkg;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_LOAD   = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_PATTERN = 2'd0,
      CSR_FN      = 2'd1,
      CSR_SWAP    = 2'd2,
      CSR_NONE    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HIST,
      ST_EVAL,
      ST_MAP,
      ST_CLASS,
      ST_SEARCH,
      ST_SHIFT,
      ST_BMRD,
      ST_BMWR,
      ST_DONE
   } state_type;

   localparam logic [7:0] MOD_FIRST = 8'hE0;
   localparam int         MAX_SLOTS = 6;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] row;
      logic [3:0] col;
      logic [1:0] layer;
      logic [7:0] entry_code;
      logic       sample_level;
      logic [4:0] byte_index;
   } req_type;

   typedef struct packed {
      logic [7:0] modifier_bits;
      logic [7:0] slot0;
      logic [7:0] slot1;
      logic [7:0] slot2;
      logic [7:0] slot3;
      logic [7:0] slot4;
      logic [7:0] slot5;
      logic       report_ready;
      logic [7:0] bitmap_byte;
   } rsp_type;

   // sequencer to slot unit
   typedef struct packed {
      logic       clear;
      logic       cmp;
      logic       shift;
      logic       append;
      logic [2:0] idx;
      logic [7:0] code;
   } slot_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/core/kmh_slots.sv
`default_nettype none
// rollover list; one compare or one shift step per cycle
module kmh_slots
   import kmh_pkg::*;
#(
   parameter int SLOTS = 6
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire slot_ctl_type ctl,
   output logic              hit,
   output logic [2:0]        count,
   output logic [7:0]        slots [MAX_SLOTS]
);
   logic [7:0] slot_ff [MAX_SLOTS];
   logic [2:0] count_ff;

   always_comb begin
      hit = (slot_ff[ctl.idx < 3'(MAX_SLOTS) ? ctl.idx : 3'd0] == ctl.code);
      count = count_ff;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slots[i] = (i < SLOTS) ? slot_ff[i] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) slot_ff[i] <= 8'd0;
         count_ff <= 3'd0;
      end else if (ctl.append) begin
         slot_ff[ctl.idx] <= ctl.code;
         count_ff <= count_ff + 3'd1;
      end else if (ctl.shift) begin
         if (ctl.idx + 3'd1 < count_ff) begin
            slot_ff[ctl.idx] <= slot_ff[ctl.idx + 3'd1];
         end else begin
            slot_ff[ctl.idx] <= 8'd0;
            count_ff <= count_ff - 3'd1;
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/key_matrix_hid_report_engine_core.sv
// Keyboard matrix debounce and HID report engine.
// req_ channel: one operation a beat (sample, keymap load, bitmap read).
// rsp_ channel: one report beat for every request beat, in order.
// csr_ channel: writes debounce pattern, fn, swap and none codes; the user
// must write only while idle, the block does not enforce it. Always ready.
// After acceptance, every request passes a history read and an evaluate
// step; a bitmap read adds a bitmap step; a key event adds a keymap read
// and a classify step, a press with the list full then a bitmap read and
// write, a release a list search, then a shift or, if not found, a bitmap write.
// The list is walked one slot a cycle through a single compare/shift unit,
// and history, keymap and bitmap memories each take one registered read.
// One request in flight at a time: req_ready is low from acceptance until
// the response beat is taken, so a new request is accepted only after
// rsp_valid has fallen.
// Reset: a clearing pass over max(ROWS*COLS, BITMAP_BYTES) addresses (84 by
// default) zeroes history, stable states and bitmap, with req_ready low;
// modifiers and list clear at once; the keymap is undefined until loaded.
// A stalled receiver holds the response steady and blocks new requests.
`default_nettype none
module key_matrix_hid_report_engine_core
   import kmh_pkg::*;
#(
   parameter int ROWS = 6,
   parameter int COLS = 14,
   parameter int LAYERS = 3,
   parameter int BITMAP_BYTES = 16,
   parameter int SLOTS = 6
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   localparam int KEYS = ROWS * COLS;
   localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int MW = (LAYERS * KEYS > 1) ? $clog2(LAYERS * KEYS) : 1;
   localparam int BW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   localparam int SWEEP = (KEYS > BITMAP_BYTES) ? KEYS : BITMAP_BYTES;
   localparam int SW = $clog2(SWEEP + 1);

   logic [7:0] pattern_ff, fn_code_ff, swap_code_ff, none_code_ff;
   // bit 8: stable state, bits 7:0: history
   logic [8:0] hist_mem [KEYS];
   logic [7:0] map_mem [LAYERS * KEYS];
   logic [7:0] bm_mem [BITMAP_BYTES];
   logic [8:0] hist_rd_ff;
   logic [7:0] map_rd_ff, bm_rd_ff;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [KW-1:0] key_ff;
   logic       in_matrix_ff;
   logic       fn_held_ff, swap_held_ff;
   logic [7:0] mod_ff;
   logic       pressed_ff, pressed_in;
   logic       ready_ff, ready_in;
   logic [7:0] bbyte_ff, bbyte_in;
   logic [7:0] code_ff, code_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] hist_new;
   logic [8:0] hist_wdata;
   logic [1:0] act_layer;
   logic [MW-1:0] map_addr;
   logic [BW-1:0] bm_addr;
   logic       bm_ok;
   logic       rsp_valid_ff;
   slot_ctl_type ctl;
   logic       hit;
   logic [2:0] count;
   logic [7:0] slots [MAX_SLOTS];
   logic       hist_we, map_we, bm_we, fn_we, swap_we, mod_we;
   logic [7:0] bm_wdata, mod_in;
   logic [SW-1:0] sweep_ff;
   logic        sweeping;

   assign sweeping = (sweep_ff < SW'(SWEEP));
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff && !sweeping;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= 8'hFF;
         fn_code_ff <= 8'hF0;
         swap_code_ff <= 8'hF1;
         none_code_ff <= 8'h00;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN: pattern_ff <= csr_wdata;
            CSR_FN: fn_code_ff <= csr_wdata;
            CSR_SWAP: swap_code_ff <= csr_wdata;
            CSR_NONE: none_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign hist_new = {hist_rd_ff[6:0], req_ff.sample_level};
   assign act_layer = (fn_held_ff && LAYERS > 1) ? 2'd1 :
                      (swap_held_ff && LAYERS > 2) ? 2'd2 : 2'd0;
   assign map_addr = MW'(32'(act_layer) * KEYS + 32'(key_ff));
   assign bm_addr = BW'(code_ff[7:3]);
   assign bm_ok = 32'(code_ff[7:3]) < BITMAP_BYTES;

   // clearing pass after reset shares the write ports
   always_ff @(posedge clock) begin
      hist_rd_ff <= hist_mem[key_ff];
      map_rd_ff <= map_mem[map_addr];
      bm_rd_ff <= bm_mem[bm_addr];
      if (sweeping) begin
         if (32'(sweep_ff) < KEYS) hist_mem[KW'(sweep_ff)] <= 9'd0;
         if (32'(sweep_ff) < BITMAP_BYTES) bm_mem[BW'(sweep_ff)] <= 8'd0;
      end else begin
         if (hist_we) hist_mem[key_ff] <= hist_wdata;
         if (bm_we) bm_mem[bm_addr] <= bm_wdata;
      end
      if (map_we) map_mem[MW'(32'(req_ff.layer) * KEYS + 32'(key_ff))] <= req_ff.entry_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fn_held_ff <= 1'b0;
         swap_held_ff <= 1'b0;
         mod_ff <= 8'd0;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (sweeping) sweep_ff <= sweep_ff + 1'b1;
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (fn_we) fn_held_ff <= pressed_ff;
         if (swap_we) swap_held_ff <= pressed_ff;
         if (mod_we) mod_ff <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
         key_ff <= KW'(32'(req_data.row) * COLS + 32'(req_data.col));
         in_matrix_ff <= (32'(req_data.row) < ROWS) && (32'(req_data.col) < COLS);
      end
      pressed_ff <= pressed_in;
      ready_ff <= ready_in;
      bbyte_ff <= bbyte_in;
      code_ff <= code_in;
      idx_ff <= idx_in;
   end

   kmh_slots #(.SLOTS(SLOTS)) u_slots (
      .clock(clock), .reset(reset), .ctl(ctl),
      .hit(hit), .count(count), .slots(slots)
   );

   always_comb begin
      state_in = state_ff;
      pressed_in = pressed_ff;
      ready_in = ready_ff;
      bbyte_in = bbyte_ff;
      code_in = code_ff;
      idx_in = idx_ff;
      ctl = '0;
      ctl.idx = idx_ff;
      ctl.code = code_ff;
      hist_we = 1'b0; map_we = 1'b0; bm_we = 1'b0;
      fn_we = 1'b0; swap_we = 1'b0; mod_we = 1'b0;
      hist_wdata = {hist_rd_ff[8], hist_new};
      bm_wdata = bm_rd_ff;
      mod_in = mod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready && !sweeping) begin
               ready_in = 1'b0;
               bbyte_in = 8'd0;
               code_in = {req_data.byte_index, 3'd0};
               state_in = ST_HIST;
            end
         end
         // history and bitmap reads in flight
         ST_HIST: state_in = ST_EVAL;
         ST_EVAL: begin
            code_in = {3'd0, req_ff.byte_index};
            state_in = ST_DONE;
            case (opcode_type'(req_ff.opcode))
               OP_SAMPLE: begin
                  if (in_matrix_ff) begin
                     hist_we = 1'b1;
                     if (hist_new == pattern_ff && !hist_rd_ff[8]) begin
                        pressed_in = 1'b1; hist_wdata = {1'b1, hist_new};
                        state_in = ST_MAP;
                     end else if (hist_new == 8'd0 && hist_rd_ff[8]) begin
                        pressed_in = 1'b0; hist_wdata = {1'b0, hist_new};
                        state_in = ST_MAP;
                     end
                  end
               end
               OP_LOAD: map_we = in_matrix_ff && (32'(req_ff.layer) < LAYERS);
               OP_READ: begin
                  code_in = {req_ff.byte_index, 3'd0};
                  state_in = ST_BMRD;
               end
               default: ;
            endcase
         end
         ST_BMRD: begin
            if (opcode_type'(req_ff.opcode) == OP_READ) begin
               bbyte_in = (32'(req_ff.byte_index) < BITMAP_BYTES) ? bm_rd_ff : 8'd0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_BMWR;
            end
         end
         ST_MAP: state_in = ST_CLASS;
         ST_CLASS: begin
            code_in = map_rd_ff;
            idx_in = 3'd0;
            state_in = ST_DONE;
            if (map_rd_ff == none_code_ff) begin
            end else if (map_rd_ff == fn_code_ff) begin
               fn_we = 1'b1;
            end else if (map_rd_ff == swap_code_ff) begin
               swap_we = 1'b1;
            end else if (map_rd_ff[7:3] == MOD_FIRST[7:3]) begin
               mod_we = 1'b1;
               mod_in = pressed_ff ? (mod_ff | (8'd1 << map_rd_ff[2:0]))
                                   : (mod_ff & ~(8'd1 << map_rd_ff[2:0]));
            end else begin
               ready_in = 1'b1;
               if (pressed_ff && 32'(count) < SLOTS) begin
                  ctl.append = 1'b1;
                  ctl.idx = count;
                  ctl.code = map_rd_ff;
               end else begin
                  state_in = pressed_ff ? ST_BMRD : ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (idx_ff >= count) begin
               state_in = ST_BMWR;
            end else if (hit) begin
               state_in = ST_SHIFT;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_SHIFT: begin
            ctl.shift = 1'b1;
            idx_in = idx_ff + 3'd1;
            if (idx_ff + 3'd1 >= count) state_in = ST_DONE;
         end
         ST_BMWR: begin
            bm_we = bm_ok;
            bm_wdata = pressed_ff ? (bm_rd_ff | (8'd1 << code_ff[2:0]))
                                  : (bm_rd_ff & ~(8'd1 << code_ff[2:0]));
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_data.modifier_bits <= mod_ff;
         rsp_data.slot0 <= slots[0];
         rsp_data.slot1 <= slots[1];
         rsp_data.slot2 <= slots[2];
         rsp_data.slot3 <= slots[3];
         rsp_data.slot4 <= slots[4];
         rsp_data.slot5 <= slots[5];
         rsp_data.report_ready <= ready_ff;
         rsp_data.bitmap_byte <= bbyte_ff;
      end
   end

`include "key_matrix_hid_report_engine_core_macros.svh"
   `KMH_ASSERT_IMPL(a_busy_no_ready, clock, reset, state_ff != ST_IDLE, !req_ready)
   `KMH_ASSERT_NEXT(a_done_valid, clock, reset, state_ff == ST_DONE, rsp_valid)
   `KMH_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, 32'(count) <= SLOTS)
endmodule
`default_nettype wire
